>>> src/spg_pkg.sv
// Shared constants, codes and control types for the Sobol point generator.
`default_nettype none

package spg_pkg;

  localparam int MAX_DEGREE = 18;
  localparam int MAX_BITS   = 32;

  localparam int WORD_W        = 32;
  localparam int INDEX_W       = 33;
  localparam int REQ_W         = 2;
  localparam int DIR_INDEX_W   = 5;
  localparam int DIR_VALUE_W   = 18;
  localparam int FIRST_DIM_W   = 1;
  localparam int POLY_DEGREE_W = 5;
  localparam int COEFF_W       = 17;
  localparam int POINT_BITS_W  = 6;
  localparam int STATUS_W      = 2;

  localparam int DEG_W   = $clog2(MAX_DEGREE + 1);
  localparam int BITS_W  = $clog2(MAX_BITS + 1);
  localparam int ADDR_W  = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam int INIT_W  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int TRAIL_W = $clog2(INDEX_W + 1);

  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 4;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BUILD = 2'd1;
  localparam logic [REQ_W-1:0] REQ_GEN   = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 2'd2;

  // register indexes
  localparam logic [1:0] REG_FIRST_DIM   = 2'd0;
  localparam logic [1:0] REG_POLY_DEGREE = 2'd1;
  localparam logic [1:0] REG_POLY_COEFF  = 2'd2;
  localparam logic [1:0] REG_POINT_BITS  = 2'd3;

  typedef struct packed {
    logic load;
    logic build_start;
    logic fill_wr;
    logic rec_issue;
    logic rec_wr;
    logic gen_step;
  } spg_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic need_rec;
    logic k_last;
    logic i_last;
    logic out_free;
  } spg_sts_t;

  typedef struct packed {
    logic [FIRST_DIM_W-1:0]   first_dim_mode;
    logic [POLY_DEGREE_W-1:0] poly_degree;
    logic [COEFF_W-1:0]       poly_coeff_bits;
    logic [POINT_BITS_W-1:0]  point_bits;
  } spg_cfg_t;

endpackage

`default_nettype wire

>>> src/spg_ifs.sv
// Valid/ready channel interfaces for request and result beats.
`default_nettype none

interface spg_req_if;
  import spg_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [REQ_W-1:0]       req_type;
  logic [DIR_INDEX_W-1:0] dir_index;
  logic [DIR_VALUE_W-1:0] dir_value;

  modport source (output valid, output req_type, output dir_index, output dir_value,
                  input ready);
  modport sink (input valid, input req_type, input dir_index, input dir_value,
                output ready);
endinterface

interface spg_rsp_if;
  import spg_pkg::*;
  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   point_value;
  logic [WORD_W-1:0]   point_index;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output point_value, output point_index, output status,
                  input ready);
  modport sink (input valid, input point_value, input point_index, input status,
                output ready);
endinterface

`default_nettype wire

>>> src/spg_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module spg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                              wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic      [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/spg_cfg.sv
// APB configuration registers.
`default_nettype none

module spg_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [spg_pkg::PADDR_W-1:0]        paddr,
  input  wire logic [spg_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [spg_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                    pready,
  output spg_pkg::spg_cfg_t                       cfg
);
  import spg_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_dim_mode  <= '0;
      cfg.poly_degree     <= POLY_DEGREE_W'(1);
      cfg.poly_coeff_bits <= '0;
      cfg.point_bits      <= POINT_BITS_W'(10);
    end else if (wr_en) begin
      case (reg_sel)
        REG_FIRST_DIM:   cfg.first_dim_mode  <= pwdata[FIRST_DIM_W-1:0];
        REG_POLY_DEGREE: cfg.poly_degree     <= pwdata[POLY_DEGREE_W-1:0];
        REG_POLY_COEFF:  cfg.poly_coeff_bits <= pwdata[COEFF_W-1:0];
        REG_POINT_BITS:  cfg.point_bits      <= pwdata[POINT_BITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FIRST_DIM:   prdata = APB_DATA_W'(cfg.first_dim_mode);
      REG_POLY_DEGREE: prdata = APB_DATA_W'(cfg.poly_degree);
      REG_POLY_COEFF:  prdata = APB_DATA_W'(cfg.poly_coeff_bits);
      REG_POINT_BITS:  prdata = APB_DATA_W'(cfg.point_bits);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> src/spg_ctrl.sv
// Controller state machine: request dispatch, table build sequencing, point step.
`default_nettype none

module spg_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic [spg_pkg::REQ_W-1:0]      req_type,
  output logic                                in_ready,
  input  wire spg_pkg::spg_sts_t              sts,
  output spg_pkg::spg_cmd_t                   cmd
);
  import spg_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FILL  = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_GEN   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (req_type)
            REQ_LOAD: cmd.load = 1'b1;
            REQ_BUILD: begin
              cmd.build_start = 1'b1;
              state_next      = S_FILL;
            end
            REQ_GEN: state_next = S_GEN;
            default: ;
          endcase
        end
      end
      S_FILL: begin
        // seed entries from the initial direction numbers, or with single set bits in first-dimension mode
        cmd.fill_wr = 1'b1;
        if (sts.fill_last) begin
          state_next = sts.need_rec ? S_ISSUE : S_IDLE;
        end
      end
      S_ISSUE: begin
        cmd.rec_issue = 1'b1;
        if (sts.k_last) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.rec_wr = 1'b1;
        state_next = sts.i_last ? S_IDLE : S_ISSUE;
      end
      S_GEN: begin
        // hold until the result register can take the beat
        if (sts.out_free) begin
          cmd.gen_step = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_build_enters_fill: assert property (@(posedge clk) disable iff (rst)
    cmd.build_start |=> (state == S_FILL))
    else $error("build did not start the fill pass");

  a_step_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.gen_step |-> sts.out_free)
    else $error("point step with result register occupied");

  a_write_after_issue: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> ($past(state) == S_ISSUE))
    else $error("recurrence write without a preceding read");

endmodule

`default_nettype wire

>>> src/spg_dpath.sv
// Datapath: initial direction numbers, direction table, recurrence, point state.
`default_nettype none

module spg_dpath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire spg_pkg::spg_cfg_t                   cfg,
  input  wire spg_pkg::spg_cmd_t                   cmd,
  output spg_pkg::spg_sts_t                        sts,
  input  wire logic [spg_pkg::DIR_INDEX_W-1:0]     dir_index,
  input  wire logic [spg_pkg::DIR_VALUE_W-1:0]     dir_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [spg_pkg::WORD_W-1:0]          point_value,
  output logic      [spg_pkg::WORD_W-1:0]          point_index,
  output logic      [spg_pkg::STATUS_W-1:0]        status
);
  import spg_pkg::*;

  logic                   ld_ok;
  logic [INIT_W-1:0]      ld_addr;
  logic                   init_we;
  logic [INIT_W-1:0]      init_raddr;
  logic [DIR_VALUE_W-1:0] init_rdata;

  // clamped configuration at build
  logic [BITS_W-1:0] cfg_l;
  logic [DEG_W-1:0]  cfg_s;
  logic [BITS_W-1:0] first_n;

  // build registers
  logic              bfdm;
  logic [DEG_W-1:0]  bs;
  logic [COEFF_W-1:0] bcoeff;
  logic [BITS_W-1:0] bl;
  logic [BITS_W-1:0] fill_n;
  logic              need_rec;
  logic [BITS_W-1:0] ri;
  logic [DEG_W-1:0]  rk;

  // recurrence accumulate
  logic              pend;
  logic              pend_first;
  logic              pend_base;
  logic              pend_use;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] acc_next;
  logic [WORD_W-1:0] term;
  logic [DEG_W-1:0]  cbit;
  logic              coeff_on;

  // fill value
  logic [DIR_VALUE_W-1:0]          fill_m;
  logic [DIR_VALUE_W+WORD_W-1:0]   fill_wide;
  logic [WORD_W-1:0]               fill_val;

  // generator state
  logic              built;
  logic [BITS_W-1:0] built_bits;
  logic [WORD_W-1:0] point;
  logic [INDEX_W-1:0] index;
  logic [TRAIL_W-1:0] trail;
  logic              exhausted;
  logic              do_xor;

  // table memory
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic [BITS_W-1:0] rec_addr;

  assign ld_ok   = (dir_index >= DIR_INDEX_W'(1)) && (dir_index <= DIR_INDEX_W'(MAX_DEGREE));
  assign ld_addr = INIT_W'(dir_index - DIR_INDEX_W'(1));
  assign init_we = cmd.load && ld_ok;

  // fetch m_i in the cycle before its fill write
  assign init_raddr = (cmd.fill_wr && (ri < BITS_W'(MAX_DEGREE))) ? INIT_W'(ri) : '0;

  spg_ram #(
    .WIDTH(DIR_VALUE_W),
    .DEPTH(MAX_DEGREE)
  ) u_init_ram (
    .clk  (clk),
    .we   (init_we),
    .waddr(ld_addr),
    .wdata(dir_value),
    .raddr(init_raddr),
    .rdata(init_rdata)
  );

  always_comb begin
    if (cfg.point_bits == '0) begin
      cfg_l = BITS_W'(1);
    end else if (cfg.point_bits > POINT_BITS_W'(MAX_BITS)) begin
      cfg_l = BITS_W'(MAX_BITS);
    end else begin
      cfg_l = BITS_W'(cfg.point_bits);
    end
    if (cfg.poly_degree == '0) begin
      cfg_s = DEG_W'(1);
    end else if (cfg.poly_degree > POLY_DEGREE_W'(MAX_DEGREE)) begin
      cfg_s = DEG_W'(MAX_DEGREE);
    end else begin
      cfg_s = DEG_W'(cfg.poly_degree);
    end
    first_n = (cfg_l <= BITS_W'(cfg_s)) ? cfg_l : BITS_W'(cfg_s);
  end

  // fill: m_i << (32-i), or 1 << (32-i) for the first dimension
  assign fill_m    = init_rdata;
  assign fill_wide = {fill_m, {WORD_W{1'b0}}} >> ri;
  assign fill_val  = bfdm ? ({1'b1, {(WORD_W-1){1'b0}}} >> (ri - BITS_W'(1)))
                          : fill_wide[WORD_W-1:0];

  // recurrence read address i-k-1
  assign rec_addr = ri - BITS_W'(rk) - BITS_W'(1);
  assign cbit     = bs - DEG_W'(1) - rk;
  assign coeff_on = (rk != bs) && (cbit < DEG_W'(COEFF_W)) && bcoeff[cbit];

  assign term     = pend_base ? (ram_rdata ^ (ram_rdata >> bs))
                              : (pend_use ? ram_rdata : '0);
  assign acc_next = (pend_first ? '0 : acc) ^ term;

  always_comb begin
    trail = TRAIL_W'(INDEX_W);
    for (int b = INDEX_W - 1; b >= 0; b--) begin
      if (!index[b]) begin
        trail = TRAIL_W'(b);
      end
    end
  end

  assign exhausted = |(index & ({INDEX_W{1'b1}} << built_bits));
  assign do_xor    = (BITS_W'(trail) < built_bits);

  always_comb begin
    ram_we    = cmd.fill_wr || cmd.rec_wr;
    ram_waddr = ADDR_W'(ri - BITS_W'(1));
    ram_wdata = cmd.rec_wr ? acc_next : fill_val;
    ram_raddr = cmd.rec_issue ? rec_addr[ADDR_W-1:0] : trail[ADDR_W-1:0];
  end

  spg_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_BITS)
  ) u_dir_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // build sequencing registers
  always_ff @(posedge clk) begin
    if (cmd.build_start) begin
      bfdm     <= cfg.first_dim_mode[0];
      bs       <= cfg_s;
      bcoeff   <= cfg.poly_coeff_bits;
      bl       <= cfg_l;
      fill_n   <= cfg.first_dim_mode[0] ? cfg_l : first_n;
      need_rec <= !cfg.first_dim_mode[0] && (BITS_W'(cfg_s) < cfg_l);
      ri       <= BITS_W'(1);
      rk       <= DEG_W'(1);
    end else if (cmd.fill_wr) begin
      ri <= ri + BITS_W'(1);
    end else if (cmd.rec_issue) begin
      rk <= rk + DEG_W'(1);
    end else if (cmd.rec_wr) begin
      ri <= ri + BITS_W'(1);
      rk <= DEG_W'(1);
    end
    if (pend) begin
      acc <= acc_next;
    end
    pend_first <= (rk == DEG_W'(1));
    pend_base  <= (rk == bs);
    pend_use   <= coeff_on;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.rec_issue;
    end
  end

  assign sts.fill_last = (ri == fill_n);
  assign sts.need_rec  = need_rec;
  assign sts.k_last    = (rk == bs);
  assign sts.i_last    = (ri == bl);
  assign sts.out_free  = !out_valid || out_ready;

  // point state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      built      <= 1'b0;
      built_bits <= BITS_W'(1);
      point      <= '0;
      index      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.build_start) begin
        built      <= 1'b1;
        built_bits <= cfg_l;
        point      <= '0;
        index      <= '0;
      end else if (cmd.gen_step && built && !exhausted) begin
        if (do_xor) begin
          point <= point ^ ram_rdata;
        end
        index <= index + INDEX_W'(1);
      end
      if (cmd.gen_step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gen_step) begin
      if (!built) begin
        point_value <= '0;
        point_index <= '0;
        status      <= ST_NOT_BUILT;
      end else if (exhausted) begin
        point_value <= '0;
        point_index <= index[WORD_W-1:0];
        status      <= ST_EXHAUSTED;
      end else begin
        point_value <= point;
        point_index <= index[WORD_W-1:0];
        status      <= ST_OK;
      end
    end
  end

  a_index_bounded: assert property (@(posedge clk) disable iff (rst)
    built |-> (index <= (INDEX_W'(1) << built_bits)))
    else $error("point index ran past the table range");

  a_step_loads_result: assert property (@(posedge clk) disable iff (rst)
    cmd.gen_step |=> out_valid)
    else $error("point step did not present a result");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.fill_wr || cmd.rec_wr) |-> (ri >= BITS_W'(1) && ri <= bl))
    else $error("direction table write outside 1..L");

endmodule

`default_nettype wire

>>> src/sobol_point_generator.sv
// Top level of the one-dimension Sobol point generator.
//
//  channel   dir   protocol      beat contents
//  request   in    valid/ready   req_type, dir_index, dir_value
//  result    out   valid/ready   point_value, point_index, status
//  config    in    APB           first_dim_mode, poly_degree, poly_coeff_bits, point_bits
//
// Load: written on acceptance. Generate: accept, then direction table read and XOR, the
// read being registered in the direction table RAM; the second step waits for room in the result register.
// Build: accept, then a fill of F entries, F = L in first-dimension mode, else min(L, s), then
// the recurrence for the remaining L - s entries when it runs (not first-dimension mode and s < L);
// each recurrence entry takes s table reads through the single RAM read port plus a write.
// Synchronous reset clears control and point state; table contents are not cleared.
// A result held in the output register does not block the next request; a generate
// stalls only while that register is still full.
`default_nettype none

module sobol_point_generator (
  input  wire logic                               clk,
  input  wire logic                               rst,
  spg_req_if.sink                                 request,
  spg_rsp_if.source                               result,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [spg_pkg::PADDR_W-1:0]        paddr,
  input  wire logic [spg_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [spg_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                    pready
);
  import spg_pkg::*;

  spg_cfg_t cfg;
  spg_cmd_t cmd;
  spg_sts_t sts;
  logic     in_ready;

  assign request.ready = in_ready;

  spg_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  spg_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(request.valid),
    .req_type(request.req_type),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  spg_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .dir_index  (request.dir_index),
    .dir_value  (request.dir_value),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .point_value(result.point_value),
    .point_index(result.point_index),
    .status     (result.status)
  );

endmodule

`default_nettype wire

>>> bench/sobol_point_generator_test.sv
// Self-checking bench for the Sobol point generator: directed cases, then random phases.
module sobol_point_generator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import spg_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 400;   // outlasts the longest build
  localparam int RANDOM_ITEMS = 1050;

  typedef struct packed {
    logic [WORD_W-1:0]   value;
    logic [WORD_W-1:0]   index;
    logic [STATUS_W-1:0] status;
  } sobol_point_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  spg_req_if req_ch ();
  spg_rsp_if pt_ch ();

  sobol_point_generator i_dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (pt_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5ns clk = ~clk;

  // Shadow copy of the generator state
  logic                     cfg_first_dim = 1'b0;
  logic [POLY_DEGREE_W-1:0] cfg_degree    = 5'd1;
  logic [COEFF_W-1:0]       cfg_coeff     = '0;
  logic [POINT_BITS_W-1:0]  cfg_bits      = 6'd10;
  logic [DIR_VALUE_W-1:0]   init_nums [MAX_DEGREE];
  logic [MAX_DEGREE-1:0]    num_loaded    = '0;
  logic [WORD_W-1:0]        dir_words [MAX_BITS];
  logic [WORD_W-1:0]        cur_point     = '0;
  logic [INDEX_W-1:0]       cur_index     = '0;
  logic                     table_ready   = 1'b0;
  int                       latched_bits  = 1;

  sobol_point_t expected_points [$];

  bit free_run = 1'b0;
  int cycle_count = 0;
  int mismatch_count = 0;
  int req_count = 0;
  int ignored_count = 0;
  int load_count = 0;
  int build_count = 0;
  int point_count = 0;
  int exhausted_count = 0;
  int unbuilt_count = 0;
  int reg_write_count = 0;
  int setting_count = 0;

  function automatic int clamp_to(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Number of initial direction numbers a build would read
  function automatic int direction_span();
    int len;
    int deg;
    len = clamp_to(int'(cfg_bits), MAX_BITS);
    deg = clamp_to(int'(cfg_degree), MAX_DEGREE);
    if (cfg_first_dim) return 0;
    return (len <= deg) ? len : deg;
  endfunction

  function automatic void expand_direction_numbers();
    int len;
    int deg;
    int first;
    int i;
    int k;
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] v;
    len = clamp_to(int'(cfg_bits), MAX_BITS);
    deg = clamp_to(int'(cfg_degree), MAX_DEGREE);
    first = (len <= deg) ? len : deg;
    if (cfg_first_dim) begin
      for (i = 1; i <= len; i++) dir_words[i-1] = WORD_W'(64'd1 << (32 - i));
    end else begin
      for (i = 1; i <= first; i++) dir_words[i-1] = WORD_W'(64'(init_nums[i-1]) << (32 - i));
      for (i = deg + 1; i <= len; i++) begin
        base = dir_words[i-deg-1];
        v = base ^ (base >> deg);
        for (k = 1; k < deg; k++) begin
          if (cfg_coeff[deg-1-k]) v ^= dir_words[i-k-1];
        end
        dir_words[i-1] = v;
      end
    end
    latched_bits = len;
    cur_point = '0;
    cur_index = '0;
    table_ready = 1'b1;
  endfunction

  function automatic sobol_point_t next_sobol_point();
    sobol_point_t p;
    int c;
    if (!table_ready) begin
      p.value = '0;
      p.index = '0;
      p.status = ST_NOT_BUILT;
    end else if (64'(cur_index) >= (64'd1 << latched_bits)) begin
      p.value = '0;
      p.index = cur_index[WORD_W-1:0];
      p.status = ST_EXHAUSTED;
    end else begin
      p.value = cur_point;
      p.index = cur_index[WORD_W-1:0];
      p.status = ST_OK;
      // position of the lowest zero bit of the index, from one
      c = 1;
      while (c <= INDEX_W && cur_index[c-1]) c++;
      if (c <= latched_bits) cur_point ^= dir_words[c-1];
      cur_index = cur_index + 1'b1;
    end
    return p;
  endfunction

  function automatic void apply_request(input logic [REQ_W-1:0] kind,
                                        input logic [DIR_INDEX_W-1:0] idx,
                                        input logic [DIR_VALUE_W-1:0] val);
    sobol_point_t p;
    case (kind)
      REQ_LOAD: begin
        if (idx >= 1 && idx <= MAX_DEGREE) begin
          init_nums[idx-1] = val;
          num_loaded[idx-1] = 1'b1;
          load_count++;
        end else begin
          ignored_count++;
        end
      end
      REQ_BUILD: begin
        expand_direction_numbers();
        build_count++;
      end
      REQ_GEN: begin
        p = next_sobol_point();
        if (p.status == ST_EXHAUSTED) exhausted_count++;
        if (p.status == ST_NOT_BUILT) unbuilt_count++;
        expected_points.push_back(p);
      end
      default: ignored_count++;
    endcase
  endfunction

  function automatic logic [DIR_VALUE_W-1:0] odd_below_pow2(int i);
    logic [DIR_VALUE_W-1:0] mask;
    mask = DIR_VALUE_W'((64'd1 << i) - 1);
    return (DIR_VALUE_W'($urandom) & mask) | 1'b1;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap(int floor_len);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return floor_len;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    if (mismatch_count < 40)
      $display("mismatch at cycle %0d: %s got %h, wanted %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_request(input logic [REQ_W-1:0] kind,
                              input logic [DIR_INDEX_W-1:0] idx,
                              input logic [DIR_VALUE_W-1:0] val);
    int gap;
    gap = free_run ? 0 : pick_gap(0);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.dir_index <= idx;
    req_ch.dir_value <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    apply_request(kind, idx, val);
    req_count++;
  endtask

  // Drop valid, wait out every result and any build still running
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] reg_idx, input logic [APB_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({reg_idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (reg_idx)
      REG_FIRST_DIM:   cfg_first_dim = value[0];
      REG_POLY_DEGREE: cfg_degree = value[POLY_DEGREE_W-1:0];
      REG_POLY_COEFF:  cfg_coeff = value[COEFF_W-1:0];
      REG_POINT_BITS:  cfg_bits = value[POINT_BITS_W-1:0];
      default: ;
    endcase
    reg_write_count++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic fd, input logic [POLY_DEGREE_W-1:0] deg,
                            input logic [COEFF_W-1:0] coeff,
                            input logic [POINT_BITS_W-1:0] bits);
    write_register(REG_FIRST_DIM, APB_DATA_W'(fd));
    write_register(REG_POLY_DEGREE, APB_DATA_W'(deg));
    write_register(REG_POLY_COEFF, APB_DATA_W'(coeff));
    write_register(REG_POINT_BITS, APB_DATA_W'(bits));
    setting_count++;
  endtask

  // A generate before any build, an unknown request, loads at bad indexes
  task automatic test_before_build();
    send_request(REQ_GEN, '0, '0);
    send_request(REQ_UNUSED, 5'd31, 18'h3FFFF);
    send_request(REQ_LOAD, 5'd0, 18'h00000);
    send_request(REQ_LOAD, 5'd31, 18'h3FFFF);
    drain();
  endtask

  // First dimension with point_bits 0, so L is one: last point then exhausted
  task automatic test_first_dimension();
    set_config(1'b1, 5'd1, 17'd0, 6'd0);
    send_request(REQ_BUILD, '0, '0);
    repeat (3) send_request(REQ_GEN, 5'h1F, 18'h3FFFF);
    drain();
  endtask

  // Degree 0 acts as one; coefficient bits beyond the degree are ignored
  task automatic test_clamped_degree();
    set_config(1'b0, 5'd0, 17'h1FFFF, 6'd2);
    send_request(REQ_LOAD, 5'd1, 18'd3);
    send_request(REQ_BUILD, '0, '0);
    repeat (5) send_request(REQ_GEN, '0, '0);
    drain();
  endtask

  // L below the clamped degree, then a config change that must not move the end
  task automatic test_latched_length();
    set_config(1'b0, 5'd31, 17'h0AAAA, 6'd3);
    send_request(REQ_LOAD, 5'd1, 18'd1);
    send_request(REQ_LOAD, 5'd2, 18'd3);
    send_request(REQ_LOAD, 5'd3, 18'h3FFFF);
    send_request(REQ_BUILD, '0, '0);
    repeat (2) send_request(REQ_GEN, '0, '0);
    drain();
    set_config(1'b1, 5'd1, 17'd0, 6'd63);
    repeat (7) send_request(REQ_GEN, '0, '0);
    drain();
  endtask

  task automatic test_random_phases();
    int counted;
    int n;
    int r;
    int idx;
    logic                     fd;
    logic [POLY_DEGREE_W-1:0] deg;
    logic [COEFF_W-1:0]       coeff;
    logic [POINT_BITS_W-1:0]  bits;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      free_run = ($urandom_range(0, 3) == 0);
      fd = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      if (r == 0) deg = '0;
      else if (r == 1) deg = POLY_DEGREE_W'($urandom_range(MAX_DEGREE, 31));
      else if (r < 6) deg = POLY_DEGREE_W'($urandom_range(1, 5));
      else deg = POLY_DEGREE_W'($urandom_range(1, MAX_DEGREE));
      r = $urandom_range(0, 9);
      if (r == 0) coeff = '0;
      else if (r == 1) coeff = '1;
      else coeff = COEFF_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 45) bits = POINT_BITS_W'($urandom_range(1, 6));
      else if (r < 65) bits = POINT_BITS_W'($urandom_range(7, 12));
      else if (r < 75) bits = POINT_BITS_W'(MAX_BITS);
      else if (r < 82) bits = '0;
      else if (r < 90) bits = POINT_BITS_W'($urandom_range(33, 63));
      else bits = POINT_BITS_W'($urandom_range(13, 31));
      set_config(fd, deg, coeff, bits);
      // load odd initial numbers for any not yet loaded and some others at random, then build
      for (idx = 1; idx <= direction_span(); idx++) begin
        if (!num_loaded[idx-1] || $urandom_range(0, 1) == 1) begin
          send_request(REQ_LOAD, DIR_INDEX_W'(idx), odd_below_pow2(idx));
          counted++;
        end
      end
      send_request(REQ_BUILD, DIR_INDEX_W'($urandom), DIR_VALUE_W'($urandom));
      counted++;
      n = $urandom_range(40, 110);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 72) begin
          send_request(REQ_GEN, DIR_INDEX_W'($urandom), DIR_VALUE_W'($urandom));
          counted++;
        end else if (r < 84) begin
          idx = $urandom_range(1, MAX_DEGREE);
          send_request(REQ_LOAD, DIR_INDEX_W'(idx),
                       ($urandom_range(0, 3) == 0) ? DIR_VALUE_W'($urandom) : odd_below_pow2(idx));
          counted++;
        end else if (r < 91) begin
          send_request(REQ_BUILD, DIR_INDEX_W'($urandom), DIR_VALUE_W'($urandom));
          counted++;
        end else if (r < 96) begin
          send_request(REQ_UNUSED, DIR_INDEX_W'($urandom), DIR_VALUE_W'($urandom));
          counted++;
        end else begin
          idx = $urandom_range(0, 13);
          if (idx != 0) idx += MAX_DEGREE;
          send_request(REQ_LOAD, DIR_INDEX_W'(idx), DIR_VALUE_W'($urandom));
          counted++;
        end
      end
      drain();
    end
    free_run = 1'b0;
  endtask

  // Result side back-pressure
  initial begin : result_stalls
    int stall;
    pt_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!free_run && $urandom_range(0, 3) == 0) begin
        pt_ch.ready <= 1'b0;
        stall = pick_gap(1);
        repeat (stall) @(negedge clk);
      end
      pt_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_points
    sobol_point_t want;
    if (!rst && pt_ch.valid && pt_ch.ready) begin
      if (expected_points.size() == 0) begin
        report_mismatch("result beat with nothing pending, point_index", pt_ch.point_index, '0);
      end else begin
        want = expected_points.pop_front();
        point_count++;
        if (pt_ch.point_value !== want.value)
          report_mismatch("point_value", pt_ch.point_value, want.value);
        if (pt_ch.point_index !== want.index)
          report_mismatch("point_index", pt_ch.point_index, want.index);
        if (pt_ch.status !== want.status)
          report_mismatch("status", WORD_W'(pt_ch.status), WORD_W'(want.status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_points.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_LOAD;
    req_ch.dir_index = '0;
    req_ch.dir_value = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    for (int i = 0; i < MAX_DEGREE; i++) init_nums[i] = '0;
    for (int i = 0; i < MAX_BITS; i++) dir_words[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_before_build();
    test_first_dimension();
    test_clamped_degree();
    test_latched_length();
    test_random_phases();

    if (expected_points.size() != 0)
      report_mismatch("results never delivered, count", WORD_W'(expected_points.size()), '0);
    $display("%0d requests (%0d ignored): %0d loads, %0d builds, %0d points checked",
             req_count, ignored_count, load_count, build_count, point_count);
    $display("%0d exhausted and %0d unbuilt replies; %0d register writes, %0d settings, %0d cycles",
             exhausted_count, unbuilt_count, reg_write_count, setting_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
